@@ rtl/qalu_pkg.sv @@
`timescale 1ns / 1ps

package qalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DW        = 32;
    localparam int NUM_W     = DW + FRAC_BITS + 1;
    localparam int DEN_W     = DW + 1;
    localparam int QUO_W     = NUM_W;
    localparam int PROD_W    = 2 * DW;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_MIN      = 4'd4;
    localparam logic [3:0] OP_MAX      = 4'd5;
    localparam logic [3:0] OP_CMP      = 4'd6;
    localparam logic [3:0] OP_INC      = 4'd7;
    localparam logic [3:0] OP_DEC      = 4'd8;
    localparam logic [3:0] OP_FROM_INT = 4'd9;
    localparam logic [3:0] OP_TO_INT   = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [1:0] {K_SIMPLE, K_MUL, K_DIV} kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              neg;
        logic              less;
        logic              equal;
        logic              greater;
        logic [DW-1:0]     res;
        logic [1:0]        st;
        logic [DW-1:0]     ma;
        logic [DW-1:0]     mb;
        logic [PROD_W-1:0] prod;
        logic [DEN_W-1:0]  rem;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
    } item_t;

    // {overflow, value}: signed saturation of a magnitude
    function automatic logic [DW:0] sat_mag(input logic neg, input logic [PROD_W-1:0] q);
        logic ovf;
        logic [DW-1:0] val;
        if (neg)
        begin
            ovf = (|q[PROD_W-1:DW]) || (q[DW-1] && (|q[DW-2:0]));
            val = ovf ? S_MIN : (~q[DW-1:0] + 1'b1);
        end
        else
        begin
            ovf = |q[PROD_W-1:DW-1];
            val = ovf ? S_MAX : q[DW-1:0];
        end
        return {ovf, val};
    endfunction

endpackage

@@ rtl/fixed_point_q24_8_alu.sv @@
// The path from input transaction to result has 2 front stages, 41 divider
// stages and 1 output stage; every operation takes the same path.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: rst_n asynchronous, active low, clears all valid bits.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu
    import qalu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           op,
    input  logic signed [DW-1:0] operand_a,
    input  logic signed [DW-1:0] operand_b,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DW-1:0] result,
    output logic                 less,
    output logic                 equal,
    output logic                 greater,
    output logic [1:0]           status
);

    logic  adv;
    logic  valid_d [0:NUM_W];
    item_t item_d  [0:NUM_W];

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    qalu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .valid_out (valid_d[0]),
        .item_out  (item_d[0])
    );

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_div
        qalu_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (valid_d[i]),
            .item_in   (item_d[i]),
            .valid_out (valid_d[i+1]),
            .item_out  (item_d[i+1])
        );
    end

    qalu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (valid_d[NUM_W]),
        .item_in   (item_d[NUM_W]),
        .out_valid (out_valid),
        .result    (result),
        .less      (less),
        .equal     (equal),
        .greater   (greater),
        .status    (status)
    );

endmodule

@@ rtl/qalu_front.sv @@
`timescale 1ns / 1ps

module qalu_front
    import qalu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [3:0]           op,
    input  logic signed [DW-1:0] operand_a,
    input  logic signed [DW-1:0] operand_b,
    output logic                 valid_out,
    output item_t                item_out
);

    logic  s1_valid_reg;
    item_t s1_reg;
    item_t s1_next;
    logic  s2_valid_reg;
    item_t s2_reg;
    item_t s2_next;

    logic signed [DW:0]   sum;
    logic signed [DW:0]   dif;
    logic signed [DW-1:0] fi_top;
    logic                 fi_fits;
    logic [DW-1:0]        ma;
    logic [DW-1:0]        mb;

    always_comb
    begin
        sum     = {operand_a[DW-1], operand_a} + {operand_b[DW-1], operand_b};
        dif     = {operand_a[DW-1], operand_a} - {operand_b[DW-1], operand_b};
        fi_top  = operand_a >>> (DW - 1 - FRAC_BITS);
        fi_fits = (fi_top == '0) || (fi_top == '1);
        ma      = operand_a[DW-1] ? (~operand_a + 1'b1) : operand_a;
        mb      = operand_b[DW-1] ? (~operand_b + 1'b1) : operand_b;

        s1_next         = '0;
        s1_next.kind    = K_SIMPLE;
        s1_next.neg     = operand_a[DW-1] ^ operand_b[DW-1];
        s1_next.less    = operand_a < operand_b;
        s1_next.equal   = operand_a == operand_b;
        s1_next.greater = operand_a > operand_b;
        s1_next.ma      = ma;
        s1_next.mb      = mb;
        s1_next.num     = {1'b0, ma, {FRAC_BITS{1'b0}}};
        s1_next.num     = {ma, {(FRAC_BITS + 1){1'b0}}} + {{(NUM_W-DW){1'b0}}, mb};
        s1_next.den     = {mb, 1'b0};
        s1_next.res     = '0;
        s1_next.st      = ST_OK;

        case (op)
            OP_ADD, OP_SUB:
            begin
                if (op == OP_ADD)
                begin
                    s1_next.res = sum[DW-1:0];
                    if (sum[DW] != sum[DW-1])
                    begin
                        s1_next.res = sum[DW] ? S_MIN : S_MAX;
                        s1_next.st  = ST_OVF;
                    end
                end
                else
                begin
                    s1_next.res = dif[DW-1:0];
                    if (dif[DW] != dif[DW-1])
                    begin
                        s1_next.res = dif[DW] ? S_MIN : S_MAX;
                        s1_next.st  = ST_OVF;
                    end
                end
            end
            OP_MUL:
            begin
                s1_next.kind = K_MUL;
            end
            OP_DIV:
            begin
                if (operand_b == '0)
                begin
                    s1_next.st  = ST_DIV0;
                    s1_next.res = operand_a[DW-1] ? S_MIN :
                                  ((operand_a == '0) ? '0 : S_MAX);
                end
                else
                begin
                    s1_next.kind = K_DIV;
                end
            end
            OP_MIN:
            begin
                s1_next.res = (operand_a < operand_b) ? operand_a : operand_b;
            end
            OP_MAX:
            begin
                s1_next.res = (operand_a > operand_b) ? operand_a : operand_b;
            end
            OP_INC:
            begin
                if (operand_a == S_MAX)
                begin
                    s1_next.res = S_MAX;
                    s1_next.st  = ST_OVF;
                end
                else
                begin
                    s1_next.res = operand_a + 1'b1;
                end
            end
            OP_DEC:
            begin
                if (operand_a == S_MIN)
                begin
                    s1_next.res = S_MIN;
                    s1_next.st  = ST_OVF;
                end
                else
                begin
                    s1_next.res = operand_a - 1'b1;
                end
            end
            OP_FROM_INT:
            begin
                if (fi_fits)
                begin
                    s1_next.res = operand_a <<< FRAC_BITS;
                end
                else
                begin
                    s1_next.res = operand_a[DW-1] ? S_MIN : S_MAX;
                    s1_next.st  = ST_OVF;
                end
            end
            OP_TO_INT:
            begin
                s1_next.res = operand_a >>> FRAC_BITS;
            end
            default:
            begin
                s1_next.res = '0;
            end
        endcase
    end

    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.prod = s1_reg.ma * s1_reg.mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign valid_out = s2_valid_reg;
    assign item_out  = s2_reg;

endmodule

@@ rtl/qalu_div_step.sv @@
`timescale 1ns / 1ps

module qalu_div_step
    import qalu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  valid_in,
    input  item_t item_in,
    output logic  valid_out,
    output item_t item_out
);

    logic              valid_reg;
    item_t             item_reg;
    item_t             item_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // one restoring quotient bit per stage
    always_comb
    begin
        trial          = {item_in.rem, item_in.num[NUM_W-1]};
        diff           = trial - {1'b0, item_in.den};
        ge             = trial >= {1'b0, item_in.den};
        item_next      = item_in;
        item_next.rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        item_next.num  = {item_in.num[NUM_W-2:0], 1'b0};
        item_next.quo  = {item_in.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

@@ rtl/qalu_back.sv @@
`timescale 1ns / 1ps

module qalu_back
    import qalu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 valid_in,
    input  item_t                item_in,
    output logic                 out_valid,
    output logic signed [DW-1:0] result,
    output logic                 less,
    output logic                 equal,
    output logic                 greater,
    output logic [1:0]           status
);

    logic                 out_valid_reg;
    logic [DW-1:0]        result_reg;
    logic [DW-1:0]        result_next;
    logic [2:0]           flags_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [PROD_W-1:0]    q_mul;
    logic [PROD_W-1:0]    q_div;
    logic [DW:0]          sat;

    always_comb
    begin
        q_mul       = (item_in.prod + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        q_div       = {{(PROD_W-QUO_W){1'b0}}, item_in.quo};
        sat         = sat_mag(item_in.neg, (item_in.kind == K_MUL) ? q_mul : q_div);
        result_next = item_in.res;
        status_next = item_in.st;
        case (item_in.kind)
            K_MUL, K_DIV:
            begin
                result_next = sat[DW-1:0];
                status_next = sat[DW] ? ST_OVF : ST_OK;
            end
            default:
            begin
                result_next = item_in.res;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
            flags_reg  <= {item_in.less, item_in.equal, item_in.greater};
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign less      = flags_reg[2];
    assign equal     = flags_reg[1];
    assign greater   = flags_reg[0];
    assign status    = status_reg;

endmodule

@@ rtl/qalu_checker.sv @@
`timescale 1ns / 1ps

module qalu_checker
    import qalu_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [DW-1:0] result,
    input logic          less,
    input logic          equal,
    input logic          greater,
    input logic [1:0]    status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result) && $stable(status))
        else $error("output transaction changed while stalled");

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({less, equal, greater}))
        else $error("compare flags not exclusive");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_DIV0 || status == ST_OVF))
        else $error("bad status code");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind fixed_point_q24_8_alu qalu_checker u_qalu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .less      (less),
    .equal     (equal),
    .greater   (greater),
    .status    (status)
);
